[design/assert_macros.svh]
// Assertion macros shared by the RTL of the depth statistics block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

[design/mrds_pkg.sv]
// Package of the masked ROI depth statistics block: widths, codes, types.
// No dependencies; used by the interfaces and every module of the block.
package mrds_pkg;

  localparam int DEPTH_W   = 16;
  localparam int COORD_W   = 12;
  localparam int ROI_W     = 13;
  localparam int COUNT_W   = 24;
  localparam int SUM_W     = 40;
  localparam int MEAN_W    = 24;
  localparam int CFG_IDX_W = 2;

  // The mean fits in MEAN_W bits, so the quotient needs one step per bit.
  localparam int DIV_STEPS = MEAN_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [DEPTH_W-1:0] MIN_INIT  = {DEPTH_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROI_LEFT   = 2'd0,
    CFG_ROI_TOP    = 2'd1,
    CFG_ROI_WIDTH  = 2'd2,
    CFG_ROI_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    ST_ACCUM  = 2'd0,
    ST_DIVIDE = 2'd1,
    ST_WAIT   = 2'd2
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_pixel;
    logic start_div;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic div_last;
    logic out_full;
  } status_t;

endpackage

[design/mrds_if.sv]
// Valid/ready channel interfaces for pixels, results and register writes.
// Depends on mrds_pkg for the field widths.
interface mrds_in_if;
  import mrds_pkg::*;
  logic               valid;
  logic               ready;
  logic [DEPTH_W-1:0] depth;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               last_pixel;
  modport source (output valid, depth, col, row, last_pixel, input ready);
  modport sink   (input valid, depth, col, row, last_pixel, output ready);
endinterface

interface mrds_out_if;
  import mrds_pkg::*;
  logic               valid;
  logic               ready;
  logic               found;
  logic [MEAN_W-1:0]  mean_depth_q8;
  logic [DEPTH_W-1:0] depth_min;
  logic [DEPTH_W-1:0] depth_max;
  modport source (output valid, found, mean_depth_q8, depth_min, depth_max, input ready);
  modport sink   (input valid, found, mean_depth_q8, depth_min, depth_max, output ready);
endinterface

interface mrds_cfg_if;
  import mrds_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [ROI_W-1:0]     data;
  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
endinterface

[design/mrds_ctrl.sv]
// Controller of the depth statistics block: pixel intake, divide, result load.
// Depends on mrds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrds_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  mrds_pkg::status_t status_i,
  output mrds_pkg::cmd_t    cmd_o
);
  import mrds_pkg::*;

  state_t st_r, st_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_ACCUM;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_ACCUM: begin
        if (in_valid_i && in_last_i) begin
          st_nxt = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (status_i.div_last) begin
          st_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (!status_i.out_full) begin
          st_nxt = ST_ACCUM;
        end
      end
      default: st_nxt = ST_ACCUM;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (st_r)
      ST_ACCUM: begin
        in_ready_o       = 1'b1;
        cmd_o.take_pixel = in_valid_i;
        cmd_o.start_div  = in_valid_i && in_last_i;
      end
      ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
      end
      ST_WAIT: begin
        cmd_o.load_out = !status_i.out_full;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  `ASSERT_PROP(a_last_starts_div, clk, rst_n, (st_r == ST_ACCUM && in_valid_i && in_last_i) |=> (st_r == ST_DIVIDE))
  `ASSERT_PROP(a_div_ends, clk, rst_n, (st_r == ST_DIVIDE && status_i.div_last) |=> (st_r == ST_WAIT))
  `ASSERT_NEVER(a_no_load_when_full, clk, rst_n, cmd_o.load_out && status_i.out_full)

endmodule

[design/mrds_dp.sv]
// Datapath of the depth statistics block: box test, accumulators, restoring divider
// for the mean, and the result register. Depends on mrds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mrds_dp #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mrds_pkg::cmd_t                cmd_i,
  output mrds_pkg::status_t             status_o,
  input  logic [mrds_pkg::DEPTH_W-1:0]  depth_i,
  input  logic [mrds_pkg::COORD_W-1:0]  col_i,
  input  logic [mrds_pkg::COORD_W-1:0]  row_i,
  input  logic                          cfg_we_i,
  input  logic [mrds_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [mrds_pkg::ROI_W-1:0]    cfg_data_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          out_found_o,
  output logic [mrds_pkg::MEAN_W-1:0]   out_mean_o,
  output logic [mrds_pkg::DEPTH_W-1:0]  out_min_o,
  output logic [mrds_pkg::DEPTH_W-1:0]  out_max_o
);
  import mrds_pkg::*;

  localparam int BND_W = ROI_W + 2;
  localparam logic [COORD_W:0] COL_LIM = (COORD_W+1)'(MAX_COLS);
  localparam logic [COORD_W:0] ROW_LIM = (COORD_W+1)'(MAX_ROWS);

  // Box registers.
  logic [ROI_W-1:0] roi_left_r, roi_top_r, roi_width_r, roi_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      roi_left_r   <= '0;
      roi_top_r    <= '0;
      roi_width_r  <= '0;
      roi_height_r <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_t'(cfg_idx_i))
        CFG_ROI_LEFT:   roi_left_r   <= cfg_data_i;
        CFG_ROI_TOP:    roi_top_r    <= cfg_data_i;
        CFG_ROI_WIDTH:  roi_width_r  <= cfg_data_i;
        CFG_ROI_HEIGHT: roi_height_r <= cfg_data_i;
      endcase
    end
  end

  // Box test in a signed range wide enough for left plus width.
  logic signed [BND_W-1:0] left_s, top_s, right_s, bottom_s, col_s, row_s;
  logic                    in_box, hit;

  always_comb begin
    left_s   = {{2{roi_left_r[ROI_W-1]}}, roi_left_r};
    top_s    = {{2{roi_top_r[ROI_W-1]}}, roi_top_r};
    right_s  = left_s + $signed({2'b00, roi_width_r});
    bottom_s = top_s + $signed({2'b00, roi_height_r});
    col_s    = $signed({{(BND_W-COORD_W){1'b0}}, col_i});
    row_s    = $signed({{(BND_W-COORD_W){1'b0}}, row_i});
    in_box   = ({1'b0, col_i} < COL_LIM) && ({1'b0, row_i} < ROW_LIM) &&
               (col_s >= left_s) && (col_s < right_s) &&
               (row_s >= top_s) && (row_s < bottom_s);
    hit      = (depth_i != '0) && in_box;
  end

  // Accumulators.
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [DEPTH_W-1:0] min_r, min_nxt, max_r, max_nxt;

  always_comb begin
    count_nxt = count_r;
    sum_nxt   = sum_r;
    min_nxt   = min_r;
    max_nxt   = max_r;
    if (hit) begin
      if (count_r != COUNT_MAX) begin
        count_nxt = count_r + COUNT_W'(1);
        sum_nxt   = sum_r + {{(SUM_W-DEPTH_W){1'b0}}, depth_i};
      end
      if (depth_i < min_r) begin
        min_nxt = depth_i;
      end
      if (depth_i > max_r) begin
        max_nxt = depth_i;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.start_div) begin
      count_r <= '0;
      sum_r   <= '0;
      min_r   <= MIN_INIT;
      max_r   <= '0;
    end else if (cmd_i.take_pixel) begin
      count_r <= count_nxt;
      sum_r   <= sum_nxt;
      min_r   <= min_nxt;
      max_r   <= max_nxt;
    end
  end

  // Restoring divider: (sum << 8) / count, one quotient bit per cycle.
  // The quotient bits shift in from the right as dividend bits leave at the left.
  logic [DIV_CNT_W-1:0] div_cnt_r;
  logic [COUNT_W-1:0]   divisor_r, rem_r, rem_nxt;
  logic [MEAN_W-1:0]    quo_r, quo_nxt;
  logic [COUNT_W+1:0]   diff;
  logic                 ge;
  logic [DEPTH_W-1:0]   snap_min_r, snap_max_r;
  logic                 found_r;

  always_comb begin
    diff    = {1'b0, rem_r, quo_r[MEAN_W-1]} - {2'b00, divisor_r};
    ge      = !diff[COUNT_W+1];
    rem_nxt = ge ? diff[COUNT_W-1:0] : {rem_r[COUNT_W-2:0], quo_r[MEAN_W-1]};
    quo_nxt = {quo_r[MEAN_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_cnt_r <= '0;
    end else if (cmd_i.start_div) begin
      div_cnt_r <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (cmd_i.div_step && div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.start_div) begin
      divisor_r  <= count_nxt;
      rem_r      <= sum_nxt[SUM_W-1:SUM_W-COUNT_W];
      quo_r      <= {sum_nxt[SUM_W-COUNT_W-1:0], {(MEAN_W-SUM_W+COUNT_W){1'b0}}};
      snap_min_r <= min_nxt;
      snap_max_r <= max_nxt;
      found_r    <= (count_nxt != '0);
    end else if (cmd_i.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  // Result register.
  logic               out_valid_r, out_found_r;
  logic [MEAN_W-1:0]  out_mean_r;
  logic [DEPTH_W-1:0] out_min_r, out_max_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_found_r <= found_r;
      out_mean_r  <= found_r ? quo_r : '0;
      out_min_r   <= found_r ? snap_min_r : '0;
      out_max_r   <= found_r ? snap_max_r : '0;
    end
  end

  assign status_o.div_last = (div_cnt_r == '0);
  assign status_o.out_full = out_valid_r && !out_ready_i;

  assign out_valid_o = out_valid_r;
  assign out_found_o = out_found_r;
  assign out_mean_o  = out_mean_r;
  assign out_min_o   = out_min_r;
  assign out_max_o   = out_max_r;

  `ASSERT_PROP(a_div_count_load, clk, rst_n, cmd_i.start_div |=> (div_cnt_r == DIV_CNT_W'(DIV_STEPS - 1)))
  `ASSERT_PROP(a_found_order, clk, rst_n, (out_valid_r && out_found_r) |-> (out_min_r <= out_max_r))
  `ASSERT_PROP(a_empty_zero, clk, rst_n, (out_valid_r && !out_found_r) |-> (out_mean_r == '0 && out_min_r == '0 && out_max_r == '0))

endmodule

[design/masked_roi_depth_stats.sv]
// Top level of the masked ROI depth statistics block.
// Depends on mrds_pkg, mrds_if, mrds_ctrl and mrds_dp.
//
//   Channel  Role    Payload                                     Transfer when
//   in_ch    sink    depth, col, row, last_pixel                 valid && ready
//   out_ch   source  found, mean_depth_q8, depth_min, depth_max  valid && ready
//   cfg_ch   sink    idx (register), data (13 bits)              valid && ready
//
// Pixels transfer one per cycle while the block accumulates. A transfer with
// last_pixel set starts a restoring divide in the datapath; ready then stays
// low until the divide ends and the result is loaded, and longer if the
// previous result has not yet transferred. The result is held in an output
// register, so the next frame's pixels are taken while that result waits.
// The register port is always ready. Reset is synchronous and active low; it
// clears the box to zero and empties the accumulators and the result register.

module masked_roi_depth_stats #(
  parameter int MAX_COLS = 4096,
  parameter int MAX_ROWS = 4096
) (
  input  logic       clk,
  input  logic       rst_n,
  mrds_in_if.sink    in_ch,
  mrds_out_if.source out_ch,
  mrds_cfg_if.sink   cfg_ch
);
  import mrds_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // Register writes always taken, unchecked; user must write only when idle.
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // The controller sequences accumulation, the divide and the result load.
  mrds_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_ch.valid),
    .in_last_i  (in_ch.last_pixel),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the box, accumulators, divider and result register.
  mrds_dp #(
    .MAX_COLS (MAX_COLS),
    .MAX_ROWS (MAX_ROWS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .status_o    (status),
    .depth_i     (in_ch.depth),
    .col_i       (in_ch.col),
    .row_i       (in_ch.row),
    .cfg_we_i    (cfg_ch.valid),
    .cfg_idx_i   (cfg_ch.idx),
    .cfg_data_i  (cfg_ch.data),
    .out_ready_i (out_ch.ready),
    .out_valid_o (out_ch.valid),
    .out_found_o (out_ch.found),
    .out_mean_o  (out_ch.mean_depth_q8),
    .out_min_o   (out_ch.depth_min),
    .out_max_o   (out_ch.depth_max)
  );

endmodule
